>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LAG_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LAG_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/lag_pkg.sv
// ----------------------------------------------------------------------------
// lag_pkg
// Types and constants of the Life generation block.
// ----------------------------------------------------------------------------
package lag_pkg;

  localparam int ROWS_DEF = 32;
  localparam int COLS_DEF = 32;
  localparam int ADDR_W   = 5;
  localparam int GEN_W    = 16;

  localparam logic [GEN_W-1:0] GEN_MAX    = 16'hFFFF;
  localparam logic [GEN_W-1:0] STABLE_MIN = 16'd2;

  localparam logic [3:0] KEEP_COUNT  = 4'd2;
  localparam logic [3:0] BIRTH_COUNT = 4'd3;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_STEP = 2'd1,
    OP_READ = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_PRIME,
    ST_NEXT,
    ST_CELL,
    ST_WRITE,
    ST_LOOKUP,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [2:0] above;
    logic       left;
    logic       self;
    logic       right;
    logic [2:0] below;
  } window_t;

endpackage

>>> design/lag_if.sv
// ----------------------------------------------------------------------------
// lag_req_if / lag_rsp_if
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lag_req_if import lag_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [ADDR_W-1:0] row;
  logic [ADDR_W-1:0] column;
  logic              alive;

  modport source(output valid, output operation, output row, output column, output alive,
                 input ready);
  modport sink(input valid, input operation, input row, input column, input alive,
               output ready);
endinterface

interface lag_rsp_if import lag_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             cell_res;
  logic             stable;
  logic [GEN_W-1:0] generation;

  modport source(output valid, output cell_res, output stable, output generation,
                 input ready);
  modport sink(input valid, input cell_res, input stable, input generation,
               output ready);
endinterface

>>> design/lag_board_mem.sv
// ----------------------------------------------------------------------------
// lag_board_mem
// One board: a row-wide memory with one write and one registered read port.
// Rows never written since reset read as all dead.
// ----------------------------------------------------------------------------
module lag_board_mem import lag_pkg::*; #(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF,
  localparam int RW  = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  logic [RW-1:0]   wr_addr,
  input  logic [COLS-1:0] wr_data,
  input  logic            rd_en,
  input  logic [RW-1:0]   rd_addr,
  output logic [COLS-1:0] rd_data
);

  logic [COLS-1:0] mem [ROWS];
  logic [ROWS-1:0] row_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= row_valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

endmodule

>>> design/lag_cell_rule.sv
// ----------------------------------------------------------------------------
// lag_cell_rule
// Shared cell evaluator: counts the Moore neighbors and applies B3/S23.
// ----------------------------------------------------------------------------
module lag_cell_rule import lag_pkg::*; (
  input  window_t win,
  output logic    next_cell,
  output logic    changed
);

  logic [7:0] nbr;
  logic [3:0] count;

  always_comb begin
    nbr   = {win.above, win.left, win.right, win.below};
    count = '0;
    for (int i = 0; i < 8; i++) begin
      count = count + {3'b000, nbr[i]};
    end
    if (win.self) begin
      next_cell = (count == KEEP_COUNT) || (count == BIRTH_COUNT);
    end else begin
      next_cell = (count == BIRTH_COUNT);
    end
    changed = next_cell ^ win.self;
  end

endmodule

>>> design/life_automaton_generation_unit.sv
// ----------------------------------------------------------------------------
// life_automaton_generation_unit
// Double-buffered Life board with load, read and generation-step requests.
// ----------------------------------------------------------------------------
// One request is handled at a time. An in-range load or read passes ACCESS
// and RESP on its way to the response. A step runs PRIME, then NEXT, CELL and
// WRITE per row, then LOOKUP: a single cell evaluator visits one cell per cycle
// from three rotating row registers, NEXT taking in the next source row and
// WRITE writing the finished row back. Both boards read as dead right after
// reset through per-row valid bits, so no clearing pass is needed. The response
// register lets a new request be accepted while the previous response waits.
`include "assert_macros.svh"

module life_automaton_generation_unit import lag_pkg::*; #(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input logic      clk,
  input logic      rst,
  lag_req_if.sink  req,
  lag_rsp_if.source rsp
);

  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;

  state_t state, state_next;

  logic [RW-1:0]    row_cnt;
  logic [CW-1:0]    col_cnt;
  logic [COLS-1:0]  prev_row, cur_row, nxt_row, out_row;
  logic [1:0]       req_op;
  logic [RW-1:0]    req_row;
  logic [CW-1:0]    req_col;
  logic             req_alive;
  logic             req_inside;
  logic             cell_hold;
  logic             active;
  logic [GEN_W-1:0] gen_count;
  logic             last_changed;
  logic             step_changed;
  logic             rsp_valid;
  logic             rsp_cell;
  logic             rsp_stable;
  logic [GEN_W-1:0] rsp_gen;

  logic [ADDR_W+RW-1:0] in_row_wide;
  logic [ADDR_W+CW-1:0] in_col_wide;
  logic                 in_inside;
  logic                 accept;
  logic                 rsp_load;
  logic                 last_row;
  logic                 col_first, col_last;
  logic [RW:0]          row_plus2;
  logic                 fetch_more;

  logic            f_wr_en, s_wr_en, f_rd_en, s_rd_en;
  logic [RW-1:0]   f_wr_addr, s_wr_addr, f_rd_addr, s_rd_addr;
  logic [COLS-1:0] f_wr_data, s_wr_data, f_rd_data, s_rd_data;
  logic [COLS-1:0] src_data, act_data, col_mask, f_loaded, s_loaded;

  window_t win;
  logic    cell_next, cell_changed;

  lag_board_mem #(.ROWS(ROWS), .COLS(COLS)) u_board_first (
    .clk(clk), .rst(rst),
    .wr_en(f_wr_en), .wr_addr(f_wr_addr), .wr_data(f_wr_data),
    .rd_en(f_rd_en), .rd_addr(f_rd_addr), .rd_data(f_rd_data)
  );

  lag_board_mem #(.ROWS(ROWS), .COLS(COLS)) u_board_second (
    .clk(clk), .rst(rst),
    .wr_en(s_wr_en), .wr_addr(s_wr_addr), .wr_data(s_wr_data),
    .rd_en(s_rd_en), .rd_addr(s_rd_addr), .rd_data(s_rd_data)
  );

  lag_cell_rule u_cell_rule (
    .win(win),
    .next_cell(cell_next),
    .changed(cell_changed)
  );

  assign in_row_wide = {{RW{1'b0}}, req.row};
  assign in_col_wide = {{CW{1'b0}}, req.column};
  assign in_inside   = (in_row_wide < (ADDR_W+RW)'(ROWS)) &&
                       (in_col_wide < (ADDR_W+CW)'(COLS));

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign rsp_load  = (state == ST_RESP) && (!rsp_valid || rsp.ready);

  assign last_row   = (row_cnt == RW'(ROWS - 1));
  assign col_first  = (col_cnt == '0);
  assign col_last   = (col_cnt == CW'(COLS - 1));
  assign row_plus2  = {1'b0, row_cnt} + (RW+1)'(2);
  assign fetch_more = (row_plus2 < (RW+1)'(ROWS));

  assign src_data = active ? s_rd_data : f_rd_data;
  assign act_data = active ? s_rd_data : f_rd_data;
  assign col_mask = {{(COLS-1){1'b0}}, 1'b1} << req_col;
  assign f_loaded = (f_rd_data & ~col_mask) | (req_alive ? col_mask : '0);
  assign s_loaded = (s_rd_data & ~col_mask) | (req_alive ? col_mask : '0);

  assign win.above = {prev_row[COLS-1] & ~col_first, prev_row[0], prev_row[1] & ~col_last};
  assign win.left  = cur_row[COLS-1] & ~col_first;
  assign win.self  = cur_row[0];
  assign win.right = cur_row[1] & ~col_last;
  assign win.below = {nxt_row[COLS-1] & ~col_first, nxt_row[0], nxt_row[1] & ~col_last};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    f_wr_en    = 1'b0;
    s_wr_en    = 1'b0;
    f_wr_addr  = row_cnt;
    s_wr_addr  = row_cnt;
    f_wr_data  = out_row;
    s_wr_data  = out_row;
    f_rd_en    = 1'b0;
    s_rd_en    = 1'b0;
    f_rd_addr  = req_row;
    s_rd_addr  = req_row;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.operation == OP_STEP) begin
            f_rd_en    = ~active;
            s_rd_en    = active;
            f_rd_addr  = '0;
            s_rd_addr  = '0;
            state_next = ST_PRIME;
          end else if (in_inside) begin
            f_rd_en    = 1'b1;
            s_rd_en    = 1'b1;
            f_rd_addr  = in_row_wide[RW-1:0];
            s_rd_addr  = in_row_wide[RW-1:0];
            state_next = ST_ACCESS;
          end else begin
            state_next = ST_RESP;
          end
        end
      end
      ST_ACCESS: begin
        if (req_op == OP_LOAD) begin
          f_wr_en   = 1'b1;
          s_wr_en   = 1'b1;
          f_wr_addr = req_row;
          s_wr_addr = req_row;
          f_wr_data = f_loaded;
          s_wr_data = s_loaded;
        end
        state_next = ST_RESP;
      end
      ST_PRIME: begin
        f_rd_en    = ~active;
        s_rd_en    = active;
        f_rd_addr  = RW'(1);
        s_rd_addr  = RW'(1);
        state_next = ST_NEXT;
      end
      ST_NEXT: begin
        state_next = ST_CELL;
      end
      ST_CELL: begin
        if (col_last) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        f_wr_en   = active;
        s_wr_en   = ~active;
        f_rd_en   = ~active & fetch_more;
        s_rd_en   = active & fetch_more;
        f_rd_addr = row_plus2[RW-1:0];
        s_rd_addr = row_plus2[RW-1:0];
        state_next = last_row ? ST_LOOKUP : ST_NEXT;
      end
      ST_LOOKUP: begin
        if (req_inside) begin
          f_rd_en    = ~active;
          s_rd_en    = active;
          state_next = ST_ACCESS;
        end else begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (rsp_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      gen_count    <= '0;
      last_changed <= 1'b0;
    end else if (state == ST_WRITE && last_row) begin
      active       <= ~active;
      last_changed <= step_changed;
      if (gen_count != GEN_MAX) begin
        gen_count <= gen_count + GEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          req_op     <= req.operation;
          req_row    <= in_row_wide[RW-1:0];
          req_col    <= in_col_wide[CW-1:0];
          req_alive  <= req.alive;
          req_inside <= in_inside;
        end
      end
      ST_ACCESS: begin
        cell_hold <= (req_op == OP_LOAD) ? req_alive : act_data[req_col];
      end
      ST_PRIME: begin
        prev_row     <= '0;
        cur_row      <= src_data;
        row_cnt      <= '0;
        step_changed <= 1'b0;
      end
      ST_NEXT: begin
        nxt_row <= last_row ? '0 : src_data;
        col_cnt <= '0;
      end
      ST_CELL: begin
        out_row      <= {cell_next, out_row[COLS-1:1]};
        prev_row     <= {prev_row[0], prev_row[COLS-1:1]};
        cur_row      <= {cur_row[0], cur_row[COLS-1:1]};
        nxt_row      <= {nxt_row[0], nxt_row[COLS-1:1]};
        step_changed <= step_changed | cell_changed;
        col_cnt      <= col_cnt + CW'(1);
      end
      ST_WRITE: begin
        prev_row <= cur_row;
        cur_row  <= nxt_row;
        row_cnt  <= row_cnt + RW'(1);
      end
      ST_LOOKUP: begin
      end
      ST_RESP: begin
        if (rsp_load) begin
          rsp_cell   <= req_inside & cell_hold;
          rsp_stable <= ~last_changed && (gen_count > STABLE_MIN);
          rsp_gen    <= gen_count;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.cell_res   = rsp_cell;
  assign rsp.stable     = rsp_stable;
  assign rsp.generation = rsp_gen;

  `LAG_ASSERT_NEXT(a_gen_monotonic, 1'b1, gen_count >= $past(gen_count), "generation count decreased")
  `LAG_ASSERT_NEXT(a_flip_on_step_end, state == ST_WRITE && last_row, active != $past(active), "active board did not flip")
  `LAG_ASSERT_NOW(a_stable_history, rsp.valid && rsp.stable, rsp.generation > STABLE_MIN, "stable with too few generations")
  `LAG_ASSERT_NOW(a_write_window, f_wr_en || s_wr_en, state == ST_ACCESS || state == ST_WRITE, "board written outside load or row write-back")

endmodule
